FILE: hw/rtl/antialiased_line_stepper_macros.svh
// assertion macros for the antialiased line stepper
// used by the top level only; expects clk and rst_n in scope
`ifndef ANTIALIASED_LINE_STEPPER_MACROS_SVH
`define ANTIALIASED_LINE_STEPPER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ALS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("als same-cycle check failed");

// next-cycle implication, checked out of reset
`define ALS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("als next-cycle check failed");

`endif

FILE: hw/rtl/als_pkg.sv
// shared types and constants for the antialiased line stepper
// used by als_ctrl, als_dpath and antialiased_line_stepper
package als_pkg;

  localparam int COORD_BITS_DEF  = 11;
  localparam int WEIGHT_BITS_DEF = 8;

  // error accumulator and increment width
  localparam int ACC_BITS = 16;
  // divide iteration counter
  localparam int CNT_BITS = $clog2(ACC_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ACC_BITS - 1);

  // item mode codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic start;     // load a new line and emit its first pixel
    logic step;      // advance one step and emit its first pixel
    logic div_step;  // one restoring divide iteration
    logic second;    // emit the neighbour pixel of a pair
  } als_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sloped;    // incoming start item describes a sloped line
    logic busy;      // a line is in progress
    logic pair;      // next step emits a weighted pair
  } als_status_t;

endpackage

FILE: hw/rtl/als_ctrl.sv
// controller state machine for the antialiased line stepper
// depends on als_pkg; drives commands into als_dpath
module als_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_mode,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  input  als_pkg::als_status_t  status,
  output als_pkg::als_cmd_t     cmd
);
  import als_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PAIR = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;
  logic                in_fire;
  logic                load;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    out_free  = !out_valid_r || out_ready;
    in_ready  = (state_r == S_IDLE) && out_free;
    in_fire   = in_valid && in_ready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_START) begin
            cmd.start = 1'b1;
            if (status.sloped) begin
              state_nxt = S_DIV;
              cnt_nxt   = '0;
            end
          end else if (status.busy) begin
            cmd.step = 1'b1;
            if (status.pair) begin
              state_nxt = S_PAIR;
            end
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_PAIR: begin
        if (out_free) begin
          cmd.second = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    load          = cmd.start || cmd.step || cmd.second;
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/als_dpath.sv
// datapath for the antialiased line stepper: line setup, restoring
// divider, error accumulator and output register; depends on als_pkg
module als_dpath #(
  parameter int COORD_BITS  = als_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_BITS = als_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [COORD_BITS-1:0]        in_start_x,
  input  logic [COORD_BITS-1:0]        in_start_y,
  input  logic [COORD_BITS-1:0]        in_end_x,
  input  logic [COORD_BITS-1:0]        in_end_y,
  input  als_pkg::als_cmd_t            cmd,
  output als_pkg::als_status_t         status,
  output logic signed [COORD_BITS+1:0] out_pixel_x,
  output logic [COORD_BITS:0]          out_pixel_y,
  output logic [WEIGHT_BITS-1:0]       out_level,
  output logic                         out_last_pixel
);
  import als_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int WB = WEIGHT_BITS;

  // line state
  logic                busy_r, busy_nxt;
  logic [CB-1:0]       cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CB-1:0]       final_x_r, final_x_nxt, final_y_r, final_y_nxt;
  logic [ACC_BITS-1:0] acc_r, acc_nxt, inc_r, inc_nxt;
  logic                x_neg_r, x_neg_nxt, ymaj_r, ymaj_nxt;
  logic                straight_r, straight_nxt, stx_r, stx_nxt, sty_r, sty_nxt;
  logic [CB-1:0]       steps_r, steps_nxt;
  // divider state
  logic [CB-1:0]       rem_r, rem_nxt, div_r, div_nxt;
  // output register
  logic [CB+1:0]       ox_r, ox_nxt;
  logic [CB:0]         oy_r, oy_nxt;
  logic [WB-1:0]       olvl_r, olvl_nxt;
  logic                olast_r, olast_nxt;

  // setup terms
  logic                swap, neg, ymaj, straight;
  logic [CB-1:0]       x0, y0, x1, y1, dx, dy, major, minor;
  // step terms
  logic [CB-1:0]       x_adv, steps_m1;
  logic [CB+1:0]       x_adv_ext;
  logic [ACC_BITS:0]   sum;
  logic                carry;
  // divide terms
  logic [CB:0]         rem2;
  logic [CB-1:0]       diff;
  logic                ge;

  // endpoint ordering and deltas
  always_comb begin
    swap     = in_start_y > in_end_y;
    x0       = swap ? in_end_x : in_start_x;
    y0       = swap ? in_end_y : in_start_y;
    x1       = swap ? in_start_x : in_end_x;
    y1       = swap ? in_start_y : in_end_y;
    neg      = x1 < x0;
    dx       = neg ? (x0 - x1) : (x1 - x0);
    dy       = y1 - y0;
    ymaj     = dy > dx;
    straight = (dx == '0) || (dy == '0) || (dx == dy);
    major    = ymaj ? dy : dx;
    minor    = ymaj ? dx : dy;
  end

  // step arithmetic
  always_comb begin
    x_adv     = x_neg_r ? (cur_x_r - 1'b1) : (cur_x_r + 1'b1);
    x_adv_ext = x_neg_r ? ({2'b00, cur_x_r} - 1'b1) : ({2'b00, cur_x_r} + 1'b1);
    steps_m1  = steps_r - 1'b1;
    sum       = {1'b0, acc_r} + {1'b0, inc_r};
    carry     = sum[ACC_BITS];
    rem2      = {rem_r, 1'b0};
    // remainder after subtract always fits below the divisor
    diff      = rem2[CB-1:0] - div_r;
    ge        = rem2 >= {1'b0, div_r};
  end

  assign status.sloped = !straight;
  assign status.busy   = busy_r;
  assign status.pair   = !straight_r && (steps_r > CB'(1));

  // next state
  always_comb begin
    busy_nxt     = busy_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    final_x_nxt  = final_x_r;
    final_y_nxt  = final_y_r;
    acc_nxt      = acc_r;
    inc_nxt      = inc_r;
    x_neg_nxt    = x_neg_r;
    ymaj_nxt     = ymaj_r;
    straight_nxt = straight_r;
    stx_nxt      = stx_r;
    sty_nxt      = sty_r;
    steps_nxt    = steps_r;
    rem_nxt      = rem_r;
    div_nxt      = div_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    olvl_nxt     = olvl_r;
    olast_nxt    = olast_r;

    if (cmd.start) begin
      // new line: first pixel at full level
      cur_x_nxt    = x0;
      cur_y_nxt    = y0;
      final_x_nxt  = x1;
      final_y_nxt  = y1;
      acc_nxt      = '0;
      inc_nxt      = '0;
      x_neg_nxt    = neg;
      ymaj_nxt     = ymaj;
      straight_nxt = straight;
      stx_nxt      = dx != '0;
      sty_nxt      = dy != '0;
      steps_nxt    = major;
      busy_nxt     = major != '0;
      rem_nxt      = minor;
      div_nxt      = major;
      ox_nxt       = {2'b00, x0};
      oy_nxt       = {1'b0, y0};
      olvl_nxt     = '0;
      olast_nxt    = major == '0;
    end else if (cmd.div_step) begin
      // restoring divide, one quotient bit per cycle
      rem_nxt = ge ? diff : rem2[CB-1:0];
      inc_nxt = {inc_r[ACC_BITS-2:0], ge};
    end else if (cmd.step) begin
      if (straight_r) begin
        // straight lines walk one full-level pixel per step
        if (stx_r) begin
          cur_x_nxt = x_adv;
        end
        if (sty_r) begin
          cur_y_nxt = cur_y_r + 1'b1;
        end
        steps_nxt = steps_m1;
        busy_nxt  = steps_m1 != '0;
        ox_nxt    = {2'b00, (stx_r ? x_adv : cur_x_r)};
        oy_nxt    = {1'b0, (sty_r ? (cur_y_r + 1'b1) : cur_y_r)};
        olvl_nxt  = '0;
        olast_nxt = steps_m1 == '0;
      end else if (steps_r <= CB'(1)) begin
        // final pixel snaps to the far endpoint
        steps_nxt = '0;
        busy_nxt  = 1'b0;
        cur_x_nxt = final_x_r;
        cur_y_nxt = final_y_r;
        ox_nxt    = {2'b00, final_x_r};
        oy_nxt    = {1'b0, final_y_r};
        olvl_nxt  = '0;
        olast_nxt = 1'b1;
      end else begin
        // weighted step, minor axis moves on accumulator carry
        steps_nxt = steps_m1;
        acc_nxt   = sum[ACC_BITS-1:0];
        if (ymaj_r) begin
          cur_x_nxt = carry ? x_adv : cur_x_r;
          cur_y_nxt = cur_y_r + 1'b1;
        end else begin
          cur_y_nxt = carry ? (cur_y_r + 1'b1) : cur_y_r;
          cur_x_nxt = x_adv;
        end
        ox_nxt    = {2'b00, cur_x_nxt};
        oy_nxt    = {1'b0, cur_y_nxt};
        olvl_nxt  = sum[ACC_BITS-1 -: WB];
        olast_nxt = 1'b0;
      end
    end else if (cmd.second) begin
      // neighbour pixel at the complement weight
      ox_nxt    = ymaj_r ? x_adv_ext : {2'b00, cur_x_r};
      oy_nxt    = ymaj_r ? {1'b0, cur_y_r} : ({1'b0, cur_y_r} + 1'b1);
      olvl_nxt  = acc_r[ACC_BITS-1 -: WB] ^ {WB{1'b1}};
      olast_nxt = 1'b0;
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      final_x_r  <= '0;
      final_y_r  <= '0;
      acc_r      <= '0;
      inc_r      <= '0;
      x_neg_r    <= 1'b0;
      ymaj_r     <= 1'b0;
      straight_r <= 1'b0;
      stx_r      <= 1'b0;
      sty_r      <= 1'b0;
      steps_r    <= '0;
    end else begin
      busy_r     <= busy_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      final_x_r  <= final_x_nxt;
      final_y_r  <= final_y_nxt;
      acc_r      <= acc_nxt;
      inc_r      <= inc_nxt;
      x_neg_r    <= x_neg_nxt;
      ymaj_r     <= ymaj_nxt;
      straight_r <= straight_nxt;
      stx_r      <= stx_nxt;
      sty_r      <= sty_nxt;
      steps_r    <= steps_nxt;
    end
  end

  // divider and output payload registers
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    olvl_r  <= olvl_nxt;
    olast_r <= olast_nxt;
  end

  assign out_pixel_x    = $signed(ox_r);
  assign out_pixel_y    = oy_r;
  assign out_level      = olvl_r;
  assign out_last_pixel = olast_r;

endmodule

FILE: hw/rtl/antialiased_line_stepper.sv
// antialiased line stepper: a start item gives one pixel in the cycle after
// it is taken; a sloped line then runs a restoring divide for its error
// increment and takes no new item until it ends. A step item during a line
// gives a pixel in the next cycle; a weighted pair adds its neighbour pixel,
// single-pixel steps run one item per cycle unless the output is held.
// Reset (rst_n, synchronous, active low) clears the line and out_valid only.
module antialiased_line_stepper #(
  parameter int COORD_BITS  = als_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_BITS = als_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [COORD_BITS-1:0]        in_start_x,
  input  logic [COORD_BITS-1:0]        in_start_y,
  input  logic [COORD_BITS-1:0]        in_end_x,
  input  logic [COORD_BITS-1:0]        in_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS+1:0] out_pixel_x,
  output logic [COORD_BITS:0]          out_pixel_y,
  output logic [WEIGHT_BITS-1:0]       out_level,
  output logic                         out_last_pixel
);
  import als_pkg::*;

`include "antialiased_line_stepper_macros.svh"

  als_cmd_t    cmd;
  als_status_t status;

  // sequencing
  als_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and output register
  als_dpath #(
    .COORD_BITS  (COORD_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .cmd            (cmd),
    .status         (status),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_level      (out_level),
    .out_last_pixel (out_last_pixel)
  );

  // a held result blocks new items
  `ALS_ASSERT_IMP(a_hold_blocks_in, out_valid && !out_ready, !in_ready)
  // a start item always yields a pixel
  `ALS_ASSERT_NXT(a_start_emits, in_valid && in_ready && (in_mode == MODE_START), out_valid)
  // no item is taken while the divider runs
  `ALS_ASSERT_IMP(a_div_no_accept, cmd.div_step, !in_ready)

endmodule
